// ----- hw/rtl/signed_int_to_decimal_ascii_defines.svh -----
// Assertion macros used by the checker file of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIDTOA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sidtoa check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIDTOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sidtoa check failed");

`endif

// ----- hw/rtl/sidtoa_pkg.sv -----
// Package with constants and types of the decimal text converter.
`default_nettype none

package sidtoa_pkg;

  // Default size of the digit buffer; ten digits cover any 32-bit magnitude.
  localparam int MAX_DIGITS_DEF = 10;

  // Widths of the stream fields.
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;

  // ASCII codes that the block emits.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Divide by ten as a multiply by ceil(2^35 / 10) and a shift by 35.
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;
  localparam int                 PROD_W      = 2 * VALUE_W;
  localparam int                 QUO_W       = PROD_W - RECIP_SHIFT;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// After an input is taken, the sequencer steps through ST_MUL and ST_DIV once per decimal digit.
// Digits come from one shared multiply-by-reciprocal unit (multiply, then remainder).
// Emission then sends up to 21 characters, one character per cycle while out_tready allows.
// A new input is taken once the previous run's last character is in the output register.
// Reset (synchronous, rst_n low) idles the sequencer and drops any pending output.
`default_nettype none

module signed_int_to_decimal_ascii
  import sidtoa_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value (signed)
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] text_char
  output logic             out_tlast   // last_char
);

  localparam int NDW = $clog2(MAX_DIGITS + 1);
  localparam int DIW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               minus_r, minus_nxt;
  logic               sp_r, sp_nxt;
  logic [NDW-1:0]     nd_r, nd_nxt;
  logic [DIW-1:0]     j_r, j_nxt;
  logic [DIGIT_W-1:0] dig_r [MAX_DIGITS];

  logic               dig_we;
  logic [DIW-1:0]     dig_wa;
  logic [DIGIT_W-1:0] dig_wd;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [VALUE_W-1:0] quo;
  logic [DIGIT_W-1:0] rem;
  logic               out_free;
  logic               in_acc;
  logic               raw_neg;

  sidtoa_div10 u_div10 (
    .clk  (clk),
    .load (state_r == ST_MUL),
    .mag  (mag_r),
    .quo  (quo),
    .rem  (rem)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign raw_neg    = in_tdata[VALUE_W-1];
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      minus_r     <= 1'b0;
      sp_r        <= 1'b0;
      nd_r        <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      minus_r     <= minus_nxt;
      sp_r        <= sp_nxt;
      nd_r        <= nd_nxt;
      j_r         <= j_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit buffer, least significant digit at entry zero.
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_r[dig_wa] <= dig_wd;
    end
  end

  // Sequencer: accept, extract digits, then emit characters.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    minus_nxt     = minus_r;
    sp_nxt        = sp_r;
    nd_nxt        = nd_r;
    j_nxt         = j_r;
    dig_we        = 1'b0;
    dig_wa        = nd_r[DIW-1:0];
    dig_wd        = rem;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          minus_nxt = raw_neg;
          sp_nxt    = 1'b0;
          nd_nxt    = '0;
          mag_nxt   = raw_neg ? (VALUE_W'(0) - in_tdata) : in_tdata;
          if (in_tdata == '0) begin
            // Zero prints as the single digit '0'.
            dig_we    = 1'b1;
            dig_wa    = '0;
            dig_wd    = '0;
            j_nxt     = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        dig_we  = 1'b1;
        mag_nxt = quo;
        nd_nxt  = nd_r + NDW'(1);
        j_nxt   = nd_r[DIW-1:0];
        // Stop when the quotient runs out or the digit buffer is full.
        if (quo == '0 || nd_r == NDW'(MAX_DIGITS - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (minus_r) begin
            out_char_nxt = CH_MINUS;
            minus_nxt    = 1'b0;
            sp_nxt       = 1'b1;
          end else if (sp_r) begin
            out_char_nxt = CH_SPACE;
            sp_nxt       = 1'b0;
          end else begin
            out_char_nxt = CH_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, dig_r[j_r]};
            if (j_r == '0) begin
              out_last_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              j_nxt  = j_r - DIW'(1);
              sp_nxt = 1'b1;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sidtoa_div10.sv -----
// Shared divide-by-ten unit: registered reciprocal product, combinational quotient and remainder.
`default_nettype none

module sidtoa_div10
  import sidtoa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [VALUE_W-1:0] mag,
  output logic      [VALUE_W-1:0] quo,
  output logic      [DIGIT_W-1:0] rem
);

  logic [PROD_W-1:0]  prod_r;
  logic [VALUE_W-1:0] quo_times10;
  logic [VALUE_W-1:0] diff;

  // Capture the reciprocal product; the dividend must hold until the next cycle.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= {{VALUE_W{1'b0}}, mag} * {{VALUE_W{1'b0}}, RECIP_10};
    end
  end

  // Quotient from the product, remainder by shift-and-add back-multiply.
  always_comb begin
    quo         = {{(VALUE_W-QUO_W){1'b0}}, prod_r[PROD_W-1:RECIP_SHIFT]};
    quo_times10 = (quo << 3) + (quo << 1);
    diff        = mag - quo_times10;
    rem         = diff[DIGIT_W-1:0];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sidtoa_checker.sv -----
// Port-level checker of the decimal text converter and its bind to the top level.
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

module sidtoa_checker
  import sidtoa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  logic char_ok;
  logic in_acc;

  // Only a minus sign, a space or a decimal digit may appear.
  assign char_ok = (out_tdata == CH_MINUS) || (out_tdata == CH_SPACE) ||
                   ((out_tdata >= CH_ZERO) && (out_tdata <= CH_NINE));
  assign in_acc  = in_tvalid && in_tready && (in_tdata == in_tdata);

  // A stalled result transaction keeps its character and flag.
  `SIDTOA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Every emitted character is from the decimal text alphabet.
  `SIDTOA_ASSERT_NOW(a_char_set, clk, rst_n, out_tvalid, char_ok)

  // A run never ends on a separator or a sign.
  `SIDTOA_ASSERT_NOW(a_last_digit, clk, rst_n, out_tvalid && out_tlast, (out_tdata >= CH_ZERO) && (out_tdata <= CH_NINE))

  // After an input transaction the block is busy converting.
  `SIDTOA_ASSERT_NEXT(a_busy, clk, rst_n, in_acc, !in_tready)

endmodule

bind signed_int_to_decimal_ascii sidtoa_checker u_sidtoa_checker (.*);

`default_nettype wire

// ----- tb/sv/signed_int_to_decimal_ascii_tb.sv -----
// Self-checking testbench for the signed integer to decimal text converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
  import sidtoa_pkg::*;

  localparam int DIGIT_SLOTS = MAX_DIGITS_DEF;
  localparam int TAIL_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 30;
  localparam int N_RANDOM    = 150;

  // One number waiting to be sent, with the idle phase it belongs to.
  typedef struct {
    logic [VALUE_W-1:0] value;
    int                 phase;
    bit                 drain;
  } number_item_t;

  // One expected character of the decimal text.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;

  number_item_t      numbers_pending[$];
  text_char_t        text_expected[$];
  int                n_accepted = 0;
  int                n_chars_expected = 0;
  int                n_chars_received = 0;
  int                cur_phase = 0;
  int                err_count = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;

  signed_int_to_decimal_ascii #(
    .MAX_DIGITS(MAX_DIGITS_DEF)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // Append the decimal text of one number to the expected characters.
  function automatic int predict_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digit_buf[DIGIT_SLOTS];
    bit                 neg;
    int                 nd;
    int                 added;
    neg = value[VALUE_W-1];
    mag = neg ? (VALUE_W'(0) - value) : value;
    nd = 0;
    added = 0;
    if (value == '0) begin
      text_expected.push_back('{CH_ZERO, 1'b1});
      return 1;
    end
    while (mag != '0 && nd < DIGIT_SLOTS) begin
      digit_buf[nd] = DIGIT_W'(mag % 10);
      mag = mag / 10;
      nd++;
    end
    if (neg) begin
      text_expected.push_back('{CH_MINUS, 1'b0});
      text_expected.push_back('{CH_SPACE, 1'b0});
      added += 2;
    end
    for (int j = nd - 1; j >= 0; j--) begin
      text_expected.push_back('{CH_ZERO + CHAR_W'(digit_buf[j]), j == 0});
      added++;
      if (j > 0) begin
        text_expected.push_back('{CH_SPACE, 1'b0});
        added++;
      end
    end
    return added;
  endfunction

  task automatic add_number(input logic [VALUE_W-1:0] value, input int phase,
                            input bit drain);
    numbers_pending.push_back('{value, phase, drain});
  endtask

  // Input driver: holds an offered number until it is taken, idles at random.
  always @(posedge clk) begin
    int  chars_total;
    bit  offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      chars_total = n_chars_expected;
      if (in_tvalid && in_tready) begin
        chars_total += predict_text(in_tdata);
        numbers_pending.pop_front();
        n_accepted <= n_accepted + 1;
        n_chars_expected <= chars_total;
      end
      if (!(in_tvalid && !in_tready)) begin
        offer = numbers_pending.size() > 0;
        if (offer) begin
          case (numbers_pending[0].phase)
            0: offer = $urandom_range(0, 99) >= 9;
            1: offer = $urandom_range(0, 99) >= 75;
            default: offer = 1'b1;
          endcase
          // A drain item waits until every earlier character has come out.
          if (numbers_pending[0].drain && chars_total != n_chars_received) begin
            offer = 1'b0;
          end
        end
        in_tvalid <= offer;
        if (offer) begin
          in_tdata <= numbers_pending[0].value;
          cur_phase <= numbers_pending[0].phase;
        end
      end
    end
  end

  // Output monitor: checks each character transaction and paces out_tready.
  always @(posedge clk) begin
    text_char_t want;
    bit         rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_chars_received <= n_chars_received + 1;
        if (text_expected.size() == 0) begin
          $display("%0t: unexpected character: expected none actual %h/%0b",
                   $time, out_tdata, out_tlast);
          err_count++;
        end else begin
          want = text_expected.pop_front();
          if (out_tdata !== want.ch) begin
            $display("%0t: text_char mismatch: expected %h actual %h",
                     $time, want.ch, out_tdata);
            err_count++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_char mismatch: expected %0b actual %0b",
                     $time, want.last, out_tlast);
            err_count++;
          end
        end
      end
      // One long hold-off so the block backs up into its input.
      if (!hold_done && n_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (cur_phase)
          0: rdy = $urandom_range(0, 99) >= 75;
          1: rdy = $urandom_range(0, 99) >= 9;
          default: rdy = 1'b1;
        endcase
      end
      out_tready <= rdy;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [VALUE_W-1:0] mag;
    longint unsigned    lim;
    int                 phase;
    // Field extremes, sign handling, digit counts and the most negative value.
    add_number(32'd0, 0, 1'b0);
    add_number(32'd1, 0, 1'b0);
    add_number(-32'sd1, 0, 1'b0);
    add_number(32'd9, 0, 1'b0);
    add_number(-32'sd9, 0, 1'b0);
    add_number(32'd10, 0, 1'b0);
    add_number(-32'sd10, 0, 1'b0);
    add_number(32'd100, 0, 1'b0);
    add_number(32'd12345, 0, 1'b0);
    add_number(32'h7FFF_FFFF, 0, 1'b0);
    add_number(32'h8000_0000, 0, 1'b0);
    add_number(32'h8000_0001, 0, 1'b0);
    add_number(32'd1000000000, 0, 1'b0);
    add_number(-32'sd1000000000, 0, 1'b0);
    add_number(32'd999999999, 0, 1'b0);
    add_number(-32'sd999999999, 0, 1'b0);
    add_number(32'h5555_5555, 0, 1'b0);
    add_number(32'hAAAA_AAAA, 0, 1'b0);
    add_number(32'd0, 0, 1'b0);
    // Random numbers, mostly with a random digit count and sign.
    for (int i = 0; i < N_RANDOM; i++) begin
      phase = (i < 50) ? 0 : ((i < 100) ? 1 : 2);
      if ($urandom_range(0, 7) == 0) begin
        mag = $urandom;
      end else begin
        lim = 1;
        repeat ($urandom_range(1, 10)) lim *= 10;
        mag = (lim > 64'hFFFF_FFFF) ? $urandom : VALUE_W'($urandom % lim);
        if ($urandom_range(0, 1) == 1) begin
          mag = VALUE_W'(0) - mag;
        end
      end
      add_number(mag, phase, i == 25 || i == 50 || i == 100);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every number to go in and every character to come out.
    do begin
      @(posedge clk);
    end while (numbers_pending.size() != 0 || text_expected.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule
